/* sv/dopfc_pkg.sv */
// Types, constants and microcode ROM for the odd prime factor counter.
package dopfc_pkg;

  localparam int VALUE_W = 32;
  localparam int N_W     = 31;  // working quotient, sign bit dropped
  localparam int D_W     = 16;  // trial divisor, at most sqrt(2^31) + 2
  localparam int SQ_W    = 2 * D_W;
  localparam int COUNT_W = 4;
  localparam int PC_W    = 4;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_SHR,     // drop a factor of two when the quotient is even
    OP_SQUARE,  // square the trial divisor
    OP_DIV_GO,  // divide quotient by trial divisor
    OP_COUNT,   // one more odd prime found
    OP_TAKE_Q,  // keep the quotient and divide it again
    OP_STEP_D,  // next odd trial divisor
    OP_TAIL,    // count a leftover prime above one
    OP_EMIT     // present the result
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_SMALL,
    C_EVEN,
    C_SQ_GT,
    C_DIV_BUSY,
    C_REM_NZ,
    C_REM_Z
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  localparam pc_t PC_SMALL  = 4'd0;
  localparam pc_t PC_STRIP  = 4'd1;
  localparam pc_t PC_SQUARE = 4'd2;
  localparam pc_t PC_CMP    = 4'd3;
  localparam pc_t PC_DIV    = 4'd4;
  localparam pc_t PC_WAIT1  = 4'd5;
  localparam pc_t PC_TEST   = 4'd6;
  localparam pc_t PC_COUNT  = 4'd7;
  localparam pc_t PC_TAKE   = 4'd8;
  localparam pc_t PC_WAIT2  = 4'd9;
  localparam pc_t PC_AGAIN  = 4'd10;
  localparam pc_t PC_NEXTD  = 4'd11;
  localparam pc_t PC_TAIL   = 4'd12;
  localparam pc_t PC_EMIT   = 4'd13;

  // Jump to target when the condition holds, otherwise fall through.
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    w = '{OP_NOP, C_ALWAYS, PC_EMIT};
    unique case (pc)
      PC_SMALL:  w = '{OP_NOP,    C_SMALL,    PC_EMIT};
      PC_STRIP:  w = '{OP_SHR,    C_EVEN,     PC_STRIP};
      PC_SQUARE: w = '{OP_SQUARE, C_NEVER,    PC_SMALL};
      PC_CMP:    w = '{OP_NOP,    C_SQ_GT,    PC_TAIL};
      PC_DIV:    w = '{OP_DIV_GO, C_NEVER,    PC_SMALL};
      PC_WAIT1:  w = '{OP_NOP,    C_DIV_BUSY, PC_WAIT1};
      PC_TEST:   w = '{OP_NOP,    C_REM_NZ,   PC_NEXTD};
      PC_COUNT:  w = '{OP_COUNT,  C_NEVER,    PC_SMALL};
      PC_TAKE:   w = '{OP_TAKE_Q, C_NEVER,    PC_SMALL};
      PC_WAIT2:  w = '{OP_NOP,    C_DIV_BUSY, PC_WAIT2};
      PC_AGAIN:  w = '{OP_NOP,    C_REM_Z,    PC_TAKE};
      PC_NEXTD:  w = '{OP_STEP_D, C_ALWAYS,   PC_SQUARE};
      PC_TAIL:   w = '{OP_TAIL,   C_NEVER,    PC_SMALL};
      PC_EMIT:   w = '{OP_EMIT,   C_NEVER,    PC_SMALL};
      default:   w = '{OP_NOP,    C_ALWAYS,   PC_EMIT};
    endcase
    return w;
  endfunction

endpackage

/* sv/dopfc_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
module dopfc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [dopfc_pkg::N_W-1:0] dividend,
  input  logic [dopfc_pkg::D_W-1:0] divisor,
  output logic                      busy,
  output logic [dopfc_pkg::N_W-1:0] quot,
  output logic [dopfc_pkg::D_W-1:0] rem
);
  import dopfc_pkg::*;

  localparam int CNT_W = $clog2(N_W);

  logic [CNT_W-1:0] cnt;
  logic [D_W-1:0]   dv;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             ge;

  assign trial = {rem, quot[N_W-1]};
  assign diff  = trial - {1'b0, dv};
  assign ge    = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(N_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 1'b1;
    end
  end

  // remainder stays below the divisor, so a trial that fails fits in D_W bits
  always_ff @(posedge clk) begin
    if (go) begin
      quot <= dividend;
      rem  <= '0;
      dv   <= divisor;
    end else if (busy) begin
      rem  <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
      quot <= {quot[N_W-2:0], ge};
    end
  end

endmodule

/* sv/distinct_odd_prime_factor_count.sv */
// Top level: microcoded trial-division counter of distinct odd prime factors.
// Pulse start while busy is low to hand in value; busy stays high while the
// item is worked on, and the count appears on odd_factor_count for the one
// cycle that done is high, with no way to hold it off. Negative values, zero
// and one give zero. Factors of two are stripped first, then every odd trial
// divisor up to the square root of the remaining quotient is tried in the
// bit-serial divider. A divisor that divides is counted once, and each extra
// division that takes it out starts the divider again. A new start is taken
// in the same cycle that done is high.
module distinct_odd_prime_factor_count (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dopfc_pkg::VALUE_W-1:0] value,
  output logic                          busy,
  output logic                          done,
  output logic [dopfc_pkg::COUNT_W-1:0] odd_factor_count
);
  import dopfc_pkg::*;

  pc_t                pc;
  uword_t             uw;
  logic               jump;
  logic [N_W-1:0]     n;
  logic [D_W-1:0]     d;
  logic [SQ_W-1:0]    sq;
  logic [COUNT_W-1:0] count;
  logic               div_go;
  logic               div_busy;
  logic [N_W-1:0]     div_quot;
  logic [D_W-1:0]     div_rem;
  logic [N_W-1:0]     div_dividend;

  assign uw = ucode(pc);

  always_comb begin
    case (uw.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_SMALL:    jump = n < N_W'(2);
      C_EVEN:     jump = !n[0];
      C_SQ_GT:    jump = sq > SQ_W'(n);
      C_DIV_BUSY: jump = div_busy;
      C_REM_NZ:   jump = div_rem != '0;
      C_REM_Z:    jump = div_rem == '0;
      default:    jump = 1'b0;
    endcase
  end

  assign div_go       = busy && (uw.op == OP_DIV_GO || uw.op == OP_TAKE_Q);
  assign div_dividend = (uw.op == OP_TAKE_Q) ? div_quot : n;

  dopfc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (d),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      pc   <= PC_SMALL;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        pc   <= PC_SMALL;
      end else if (busy) begin
        pc <= jump ? uw.target : pc + 1'b1;
        if (uw.op == OP_EMIT) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath; a negative value loads as zero and falls out as "small"
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      n     <= value[VALUE_W-1] ? '0 : value[N_W-1:0];
      d     <= D_W'(3);
      count <= '0;
    end else if (busy) begin
      case (uw.op)
        OP_SHR: begin
          if (!n[0]) begin
            n <= n >> 1;
          end
        end
        OP_SQUARE: sq <= d * d;
        OP_COUNT:  count <= count + 1'b1;
        OP_TAKE_Q: n <= div_quot;
        OP_STEP_D: d <= d + D_W'(2);
        OP_TAIL: begin
          if (n > N_W'(1)) begin
            count <= count + 1'b1;
          end
        end
        OP_EMIT:   odd_factor_count <= count;
        default: ;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done longer than one cycle");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> odd_factor_count <= COUNT_W'(8))
    else $error("count out of range");
  a_start_takes: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("start not taken");
  a_div_idle_go: assert property (@(posedge clk) disable iff (rst)
    div_go |-> !div_busy)
    else $error("divider restarted while running");

endmodule

/* tb/tb_distinct_odd_prime_factor_count.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the distinct odd prime factor counter.
module tb_distinct_odd_prime_factor_count;
  import dopfc_pkg::*;

  // The largest input alone is slow; everything else is kept cheap.
  localparam int          CYCLE_LIMIT = 4_000_000;
  localparam int unsigned TRIAL_CAP   = 400;
  localparam logic [63:0] VALUE_SPAN  = 64'h8000_0000;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } tally_t;

  logic               clk   = 1'b0;
  logic               rst   = 1'b1;
  logic               start = 1'b0;
  logic [VALUE_W-1:0] value = '0;
  logic               busy;
  logic               done;
  logic [COUNT_W-1:0] odd_factor_count;

  tally_t      pending_tallies[$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;

  distinct_odd_prime_factor_count dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .value            (value),
    .busy             (busy),
    .done             (done),
    .odd_factor_count (odd_factor_count)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("distinct_odd_prime_factor_count verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches = mismatches + 1;
  endtask

  // Trial division; trials counts odd divisors tried, which tracks the block's run time.
  function automatic logic [COUNT_W-1:0] odd_prime_tally(input logic [VALUE_W-1:0] v,
                                                        output int unsigned trials);
    logic [63:0] n;
    logic [63:0] d;
    int unsigned tally;
    tally  = 0;
    trials = 0;
    if (v[VALUE_W-1] || v < 2) return '0;
    n = 64'(v);
    while (n % 2 == 0) n = n >> 1;
    d = 64'd3;
    while (d * d <= n) begin
      trials = trials + 1;
      if (n % d == 0) begin
        tally = tally + 1;
        while (n % d == 0) n = n / d;
      end
      d = d + 64'd2;
    end
    if (n > 1) tally = tally + 1;
    return tally[COUNT_W-1:0];
  endfunction

  // Back to back or a short gap, rarely a long pause.
  task automatic sender_gap();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 15);
    if (r < 6) n = 0;
    else if (r < 14) n = $urandom_range(1, 4);
    else n = $urandom_range(20, 200);
    if (n > 0) begin
      start <= 1'b0;
      value <= $urandom;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_value(input logic [VALUE_W-1:0] v);
    tally_t      t;
    int unsigned trials;
    t.value = v;
    t.count = odd_prime_tally(v, trials);
    start <= 1'b1;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_tallies.push_back(t);
    sender_gap();
  endtask

  task automatic test_range_extremes();
    send_value(32'h0000_0000);
    send_value(32'h0000_0001);
    send_value(32'h0000_0002);
    send_value(32'h0000_0003);
    send_value(32'h7FFF_FFFF);  // prime, slowest input in the run
    send_value(32'h8000_0000);
    send_value(32'hFFFF_FFFF);
    send_value(32'h5555_5555);  // 5 * 17 * 257 * 65537
  endtask

  task automatic test_negative_inputs();
    send_value(32'hFFFF_FFF1);  // -15: odd factors present, still zero
    send_value(32'h8000_0001);
    send_value(32'hAAAA_AAAA);
    send_value(32'hC000_0000);
  endtask

  task automatic test_powers_of_two();
    send_value(32'd4);
    send_value(32'h0001_0000);
    send_value(32'h4000_0000);
  endtask

  task automatic test_factor_structure();
    send_value(32'd9);
    send_value(32'd15);
    send_value(32'd111546435);   // 3*5*7*11*13*17*19*23, eight factors
    send_value(32'd1784742960);  // same, times 16
    send_value(32'd1162261467);  // 3^19
    send_value(32'd63001);       // 251^2, divisor squared equals quotient
    send_value(32'd393126);      // 6 * 65521, leftover prime
  endtask

  // Smooth products cover the counting paths; raw noise stays positive only when cheap.
  task automatic test_random_mix(input int unsigned items);
    logic [VALUE_W-1:0] v;
    logic [63:0]        prod;
    logic [63:0]        f;
    int unsigned        kind;
    int unsigned        trials;
    int unsigned        shifts;
    repeat (items) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        v = $urandom;
        void'(odd_prime_tally(v, trials));
        if (trials > TRIAL_CAP) v[VALUE_W-1] = 1'b1;  // too slow as positive, send as negative
      end else if (kind == 2) begin
        v = $urandom_range(0, 5000);
      end else begin
        prod = 64'd1;
        repeat ($urandom_range(0, 9)) begin
          f = 64'(2 * $urandom_range(1, 48) + 1);
          if (prod * f < VALUE_SPAN) prod = prod * f;
        end
        if ($urandom_range(0, 2) == 0) begin
          f = 64'($urandom_range(2, 3000));
          if (prod * f < VALUE_SPAN) prod = prod * f;
        end
        shifts = $urandom_range(0, 30);
        while (shifts > 0 && (prod << 1) < VALUE_SPAN) begin
          prod   = prod << 1;
          shifts = shifts - 1;
        end
        v = prod[VALUE_W-1:0];
      end
      send_value(v);
    end
  endtask

  always @(posedge clk) begin : result_check
    tally_t t;
    if (!rst && done) begin
      if (pending_tallies.size() == 0) begin
        report_mismatch($sformatf("result %0d with no transfer pending", odd_factor_count));
      end else begin
        t = pending_tallies.pop_front();
        if (odd_factor_count !== t.count)
          report_mismatch($sformatf("value %h: count %0d, expected %0d",
                                    t.value, odd_factor_count, t.count));
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_range_extremes();
    test_negative_inputs();
    test_powers_of_two();
    test_factor_structure();
    test_random_mix(78);
    start <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("distinct_odd_prime_factor_count verification clean");
    end else begin
      $display("distinct_odd_prime_factor_count verification failed");
    end
    $finish;
  end

endmodule
